// File: rtl/lfts_pkg.sv
// lfts_pkg: shared types and codes for the led fade transition sequencer
// no dependencies; imported by every module under rtl

package lfts_pkg;

    // item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_LOOP  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_ANIM_MODE  = 2'd0;
    localparam logic [1:0] CFG_FLOOR      = 2'd1;
    localparam logic [1:0] CFG_RAMP_STEP  = 2'd2;

    localparam logic [7:0] RAMP_STEP_RESET = 8'd1;

    typedef enum logic [1:0] {
        PH_STANDBY  = 2'd0,
        PH_STARTING = 2'd1,
        PH_FADE_OUT = 2'd2,
        PH_FADE_IN  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        TR_FADE_COLOR = 2'd0,
        TR_FADE_OUT   = 2'd1,
        TR_FADE_IN    = 2'd2,
        TR_IMMEDIATE  = 2'd3
    } trans_t;

    typedef struct packed {
        logic       anim_mode;
        logic [7:0] floor_brightness;
        logic [7:0] ramp_step;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  transition_type;
        logic        load_color;
        logic [31:0] new_color;
        logic        load_brightness;
        logic [7:0]  new_brightness;
        logic [31:0] present_color;
        logic [7:0]  present_brightness;
        logic        step_due;
    } item_t;

    typedef struct packed {
        phase_t      phase;
        trans_t      active_transition;
        logic [31:0] goal_color;
        logic [31:0] shown_color;
        logic [7:0]  shown_brightness;
        logic [7:0]  goal_brightness;
        logic [7:0]  saved_brightness;
    } seq_state_t;

    typedef struct packed {
        logic        brightness_write;
        logic [7:0]  brightness_value;
        logic        color_write;
        logic [31:0] color_value;
        phase_t      phase;
    } result_t;

endpackage

// File: rtl/lfts_ramp.sv
// lfts_ramp: one brightness ramp step toward a goal, clamped at the goal
// uses lfts_pkg; instantiated by lfts_step

module lfts_ramp
    import lfts_pkg::*;
(
    input  logic [7:0] shown,
    input  logic [7:0] goal,
    input  logic [7:0] step,
    output logic [7:0] next_level
);

    logic [8:0] up_sum;
    logic [8:0] goal_plus;

    assign up_sum    = {1'b0, shown} + {1'b0, step};
    assign goal_plus = {1'b0, goal} + {1'b0, step};

    always_comb begin
        next_level = shown;
        if (goal > shown) begin
            // rising, stop at goal
            next_level = (up_sum > {1'b0, goal}) ? goal : up_sum[7:0];
        end else if (goal < shown) begin
            // falling, stop at goal
            next_level = ({1'b0, shown} < goal_plus) ? goal : (shown - step);
        end
    end

endmodule

// File: rtl/lfts_step.sv
// lfts_step: next sequencer state and result for one transaction
// uses lfts_pkg and lfts_ramp; instantiated by the top level

module lfts_step
    import lfts_pkg::*;
(
    input  item_t      item,
    input  seq_state_t st,
    input  cfg_t       cfg,
    output seq_state_t st_next,
    output result_t    res
);

    logic       do_ramp;
    logic [7:0] ramped;
    seq_state_t st_step;
    result_t    res_step;

    // ramp works against the goal left by the phase step
    lfts_ramp u_ramp (
        .shown      (st.shown_brightness),
        .goal       (st_step.goal_brightness),
        .step       (cfg.ramp_step),
        .next_level (ramped)
    );

    // phase step
    always_comb begin
        st_step  = st;
        res_step = '0;
        do_ramp  = 1'b0;

        if (item.kind == KIND_START) begin
            if (item.load_color) begin
                st_step.goal_color = item.new_color;
            end
            if (item.load_brightness) begin
                st_step.goal_brightness = item.new_brightness;
            end
            st_step.shown_color       = item.present_color;
            st_step.shown_brightness  = item.present_brightness;
            st_step.active_transition = trans_t'(item.transition_type);
            st_step.phase             = PH_STARTING;
        end else if (st.phase != PH_STANDBY) begin
            do_ramp = item.step_due;
            unique case (st.active_transition)
                TR_FADE_COLOR: begin
                    if (st.phase == PH_STARTING) begin
                        st_step.saved_brightness = st.shown_brightness;
                        st_step.goal_brightness  = cfg.floor_brightness;
                        st_step.phase            = PH_FADE_OUT;
                    end else if (st.phase == PH_FADE_OUT) begin
                        if (st.shown_brightness <= st.goal_brightness) begin
                            st_step.phase           = PH_FADE_IN;
                            st_step.shown_color     = st.goal_color;
                            st_step.goal_brightness = st.saved_brightness;
                            if (!cfg.anim_mode) begin
                                res_step.color_write = 1'b1;
                                res_step.color_value = st.goal_color;
                            end
                        end
                    end else begin
                        if (st.shown_brightness >= st.goal_brightness) begin
                            st_step.shown_color = st.goal_color;
                            st_step.phase       = PH_STANDBY;
                        end
                    end
                end
                TR_FADE_OUT: begin
                    if (st.phase == PH_STARTING) begin
                        st_step.goal_brightness = cfg.floor_brightness;
                        st_step.phase           = PH_FADE_OUT;
                    end else if (st.phase == PH_FADE_OUT) begin
                        if (st.shown_brightness <= st.goal_brightness) begin
                            st_step.phase = PH_STANDBY;
                        end
                    end
                end
                TR_FADE_IN: begin
                    if (st.phase == PH_STARTING) begin
                        st_step.phase = PH_FADE_IN;
                    end else if (st.phase == PH_FADE_IN) begin
                        if (st.shown_brightness >= st.goal_brightness) begin
                            st_step.phase = PH_STANDBY;
                        end
                    end
                end
                TR_IMMEDIATE: begin
                    res_step.color_write = 1'b1;
                    res_step.color_value = st.goal_color;
                    st_step.phase        = PH_STANDBY;
                    do_ramp              = 1'b0;
                end
                default: begin
                    st_step.phase = PH_STANDBY;
                end
            endcase
        end
    end

    // brightness ramp after the phase step
    always_comb begin
        st_next = st_step;
        res     = res_step;

        if (do_ramp) begin
            st_next.shown_brightness = ramped;
            res.brightness_write     = 1'b1;
        end

        res.brightness_value = st_next.shown_brightness;
        res.phase            = st_next.phase;
    end

endmodule

// File: rtl/led_fade_transition_sequencer.sv
// led_fade_transition_sequencer: top level, handshake, registers and state
// uses lfts_pkg and lfts_step

// Sequences LED strip transitions (fade to colour, fade out, fade in,
// immediate colour). Every input transaction gives exactly one result
// transaction. The block takes one transaction per clock unless the result
// side stalls: an input register holds the accepted transaction, and once the
// result register is free or being taken the sequencer state and the result
// register are updated together from it, so a result reaches the m_ side
// through the input register and then the result register. Throughput is set
// by that single state update stage, which handles one transaction each cycle
// while the result register drains or is being taken. Configuration registers
// (index 0 animation mode, 1 floor brightness, 2 ramp step) are written
// through cfg_wr_en / cfg_index / cfg_wdata and should only change while no
// transaction is in flight.

module led_fade_transition_sequencer
    import lfts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,

    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [1:0]  s_transition_type,
    input  logic        s_load_color,
    input  logic [31:0] s_new_color,
    input  logic        s_load_brightness,
    input  logic [7:0]  s_new_brightness,
    input  logic [31:0] s_present_color,
    input  logic [7:0]  s_present_brightness,
    input  logic        s_step_due,

    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_brightness_write,
    output logic [7:0]  m_brightness_value,
    output logic        m_color_write,
    output logic [31:0] m_color_value,
    output logic [1:0]  m_phase
);

    // configuration
    cfg_t       cfg_reg;

    // input stage
    logic       in_valid_reg;
    item_t      in_item_reg;
    item_t      s_item;

    // sequencer state and result stage
    seq_state_t state_reg;
    seq_state_t state_next;
    logic       out_valid_reg;
    result_t    out_res_reg;
    result_t    res_next;

    logic       advance;
    logic       s_take;

    // transaction moves from input register to result register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    // input register is free now or empties this cycle
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    assign s_item = '{
        kind:               s_kind,
        transition_type:    s_transition_type,
        load_color:         s_load_color,
        new_color:          s_new_color,
        load_brightness:    s_load_brightness,
        new_brightness:     s_new_brightness,
        present_color:      s_present_color,
        present_brightness: s_present_brightness,
        step_due:           s_step_due
    };

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.anim_mode        <= 1'b0;
            cfg_reg.floor_brightness <= '0;
            cfg_reg.ramp_step        <= RAMP_STEP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ANIM_MODE: cfg_reg.anim_mode        <= cfg_wdata[0];
                CFG_FLOOR:     cfg_reg.floor_brightness <= cfg_wdata;
                CFG_RAMP_STEP: cfg_reg.ramp_step        <= cfg_wdata;
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg <= s_item;
        end
    end

    // per transaction logic: phase machine and brightness ramp
    lfts_step u_step (
        .item    (in_item_reg),
        .st      (state_reg),
        .cfg     (cfg_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    // sequencer state, committed only when a transaction is processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_brightness_write = out_res_reg.brightness_write;
    assign m_brightness_value = out_res_reg.brightness_value;
    assign m_color_write      = out_res_reg.color_write;
    assign m_color_value      = out_res_reg.color_value;
    assign m_phase            = out_res_reg.phase;

`ifndef SYNTHESIS
    // sequencer state only moves when a transaction is processed
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("sequencer state changed without a transaction");

    // a colour write ends in standby (immediate) or starts the fade in
    a_color_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_color_write) |-> (m_phase == PH_STANDBY || m_phase == PH_FADE_IN))
        else $error("colour write in unexpected phase");

    // no colour value without a colour write
    a_color_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_color_write) |-> (m_color_value == '0))
        else $error("colour value set without colour write");

    // both writes together only at the colour swap into fade in
    a_both_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_color_write && m_brightness_write) |-> (m_phase == PH_FADE_IN))
        else $error("colour and brightness write outside the colour swap");
`endif

endmodule

// File: sim/led_fade_transition_sequencer_tb.sv
// led_fade_transition_sequencer_tb: self-checking testbench for the led fade transition sequencer
// depends on lfts_pkg and led_fade_transition_sequencer from rtl

module led_fade_transition_sequencer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lfts_pkg::*;

    localparam int STUCK_LIMIT = 3000;  // cycles with no transaction on either side

    // clock and reset
    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;

    // configuration port
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_wdata = '0;

    // input channel
    logic        s_valid              = 1'b0;
    logic        s_ready;
    logic        s_kind               = 1'b0;
    logic [1:0]  s_transition_type    = '0;
    logic        s_load_color         = 1'b0;
    logic [31:0] s_new_color          = '0;
    logic        s_load_brightness    = 1'b0;
    logic [7:0]  s_new_brightness     = '0;
    logic [31:0] s_present_color      = '0;
    logic [7:0]  s_present_brightness = '0;
    logic        s_step_due           = 1'b0;

    // result channel
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_brightness_write;
    logic [7:0]  m_brightness_value;
    logic        m_color_write;
    logic [31:0] m_color_value;
    logic [1:0]  m_phase;

    always #5 aclk = ~aclk;

    led_fade_transition_sequencer u_top (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_kind               (s_kind),
        .s_transition_type    (s_transition_type),
        .s_load_color         (s_load_color),
        .s_new_color          (s_new_color),
        .s_load_brightness    (s_load_brightness),
        .s_new_brightness     (s_new_brightness),
        .s_present_color      (s_present_color),
        .s_present_brightness (s_present_brightness),
        .s_step_due           (s_step_due),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_brightness_write   (m_brightness_write),
        .m_brightness_value   (m_brightness_value),
        .m_color_write        (m_color_write),
        .m_color_value        (m_color_value),
        .m_phase              (m_phase)
    );

    // our own copy of the register file, mirrors the reset values
    logic        cfg_anim  = 1'b0;
    logic [7:0]  cfg_floor = 8'd0;
    logic [7:0]  cfg_step  = RAMP_STEP_RESET;

    // our own copy of the sequencer state
    phase_t      seq_phase      = PH_STANDBY;
    trans_t      seq_trans      = TR_FADE_COLOR;
    logic [31:0] seq_goal_color = '0;
    logic [31:0] seq_shown_color = '0;
    logic [7:0]  seq_shown_bri  = '0;
    logic [7:0]  seq_goal_bri   = '0;
    logic [7:0]  seq_saved_bri  = '0;

    // strip updates predicted but not yet seen on the result side
    result_t     strip_updates_due[$];

    // pacing control
    bit          tx_steady  = 1'b0;
    bit          rx_steady  = 1'b0;
    int          burst_left = 0;
    int          rx_left    = 0;

    // bookkeeping
    int          mismatch_count = 0;
    int          stuck_cycles   = 0;
    int          starts_by_type[4] = '{0, 0, 0, 0};
    int          loop_count     = 0;
    int          bri_writes     = 0;
    int          color_writes   = 0;
    int          settings_count = 0;

    // --------------------------------------------------------------------
    // predictor: one transaction in, one strip update out
    // --------------------------------------------------------------------
    function automatic result_t advance_sequence(input item_t it);
        result_t upd;
        logic    do_ramp;
        int      s;
        int      g;
        int      d;
        upd = '0;
        if (it.kind == KIND_START) begin
            // a start always restarts from the starting phase, abandoning any fade
            if (it.load_color) seq_goal_color = it.new_color;
            if (it.load_brightness) seq_goal_bri = it.new_brightness;
            seq_shown_color = it.present_color;
            seq_shown_bri   = it.present_brightness;
            seq_trans       = trans_t'(it.transition_type);
            seq_phase       = PH_STARTING;
        end else if (seq_phase != PH_STANDBY) begin
            do_ramp = 1'b1;
            case (seq_trans)
                TR_FADE_COLOR: begin
                    if (seq_phase == PH_STARTING) begin
                        seq_saved_bri = seq_shown_bri;
                        seq_goal_bri  = cfg_floor;
                        seq_phase     = PH_FADE_OUT;
                    end else if (seq_phase == PH_FADE_OUT) begin
                        // bottom of the fade: swap the colour and head back up
                        if (seq_shown_bri <= seq_goal_bri) begin
                            seq_phase       = PH_FADE_IN;
                            seq_shown_color = seq_goal_color;
                            seq_goal_bri    = seq_saved_bri;
                            if (!cfg_anim) begin
                                upd.color_write = 1'b1;
                                upd.color_value = seq_shown_color;
                            end
                        end
                    end else begin
                        if (seq_shown_bri >= seq_goal_bri) begin
                            seq_shown_color = seq_goal_color;
                            seq_phase       = PH_STANDBY;
                        end
                    end
                end
                TR_FADE_OUT: begin
                    if (seq_phase == PH_STARTING) begin
                        seq_goal_bri = cfg_floor;
                        seq_phase    = PH_FADE_OUT;
                    end else if (seq_phase == PH_FADE_OUT) begin
                        if (seq_shown_bri <= seq_goal_bri) seq_phase = PH_STANDBY;
                    end
                end
                TR_FADE_IN: begin
                    if (seq_phase == PH_STARTING) begin
                        seq_phase = PH_FADE_IN;
                    end else if (seq_phase == PH_FADE_IN) begin
                        if (seq_shown_bri >= seq_goal_bri) seq_phase = PH_STANDBY;
                    end
                end
                default: begin
                    // immediate colour: written regardless of mode, no ramp
                    upd.color_write = 1'b1;
                    upd.color_value = seq_goal_color;
                    seq_phase       = PH_STANDBY;
                    do_ramp         = 1'b0;
                end
            endcase
            // ramp runs after the phase step, clamped at the goal
            if (do_ramp && it.step_due) begin
                s = seq_shown_bri;
                g = seq_goal_bri;
                d = cfg_step;
                if (g > s) seq_shown_bri = (s + d > g) ? g[7:0] : 8'(s + d);
                else if (g < s) seq_shown_bri = (s < g + d) ? g[7:0] : 8'(s - d);
                upd.brightness_write = 1'b1;
            end
        end
        upd.brightness_value = seq_shown_bri;
        upd.phase            = seq_phase;
        return upd;
    endfunction

    // --------------------------------------------------------------------
    // transaction builders
    // --------------------------------------------------------------------
    function automatic item_t mk_start(input trans_t t, input logic lc, input logic [31:0] nc,
                                       input logic lb, input logic [7:0] nb,
                                       input logic [31:0] pc, input logic [7:0] pb,
                                       input logic sd);
        item_t it;
        it.kind               = KIND_START;
        it.transition_type    = t;
        it.load_color         = lc;
        it.new_color          = nc;
        it.load_brightness    = lb;
        it.new_brightness     = nb;
        it.present_color      = pc;
        it.present_brightness = pb;
        it.step_due           = sd;
        return it;
    endfunction

    // loop pass with the start-only fields filled with junk
    function automatic item_t mk_loop(input logic sd);
        item_t it;
        it                    = mk_start(trans_t'($urandom_range(0, 3)),
                                         1'($urandom_range(0, 1)), $urandom,
                                         1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                         $urandom, 8'($urandom_range(0, 255)), sd);
        it.kind               = KIND_LOOP;
        return it;
    endfunction

    // brightness level: either anywhere, or close to the floor so fades finish
    function automatic logic [7:0] pick_level();
        int v;
        if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
        v = int'(cfg_floor) + int'($urandom_range(0, 48)) - 16;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    // --------------------------------------------------------------------
    // sender side
    // --------------------------------------------------------------------

    // present one transaction and hold it until taken; predict at acceptance
    task automatic send_item(input item_t it);
        s_valid              <= 1'b1;
        s_kind               <= it.kind;
        s_transition_type    <= it.transition_type;
        s_load_color         <= it.load_color;
        s_new_color          <= it.new_color;
        s_load_brightness    <= it.load_brightness;
        s_new_brightness     <= it.new_brightness;
        s_present_color      <= it.present_color;
        s_present_brightness <= it.present_brightness;
        s_step_due           <= it.step_due;
        do @(posedge aclk); while (!s_ready);
        strip_updates_due.push_back(advance_sequence(it));
        if (it.kind == KIND_START) starts_by_type[it.transition_type]++;
        else loop_count++;
    endtask

    // bursts of back-to-back transactions separated by random gaps
    task automatic sender_pause();
        int gap;
        if (tx_steady) return;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap        = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // stop sending and wait for every outstanding update, then let the pipe go quiet
    task automatic settle_pipeline();
        s_valid <= 1'b0;
        while (strip_updates_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_register(input logic [1:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_ANIM_MODE: cfg_anim  = val[0];
            CFG_FLOOR:     cfg_floor = val;
            CFG_RAMP_STEP: cfg_step  = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic anim, input logic [7:0] floor_lvl,
                                  input logic [7:0] step);
        settle_pipeline();
        set_register(CFG_ANIM_MODE, {7'd0, anim});
        set_register(CFG_FLOOR, floor_lvl);
        set_register(CFG_RAMP_STEP, step);
        cfg_wr_en <= 1'b0;
        settings_count++;
    endtask

    // --------------------------------------------------------------------
    // stimulus generators
    // --------------------------------------------------------------------

    // well-formed transitions: a start then loop passes until standby or abandoned
    task automatic run_fade_sequences(input int n_items);
        int sent;
        int cap;
        sent = 0;
        while (sent < n_items) begin
            // occasional loop pass while idle in standby
            if (seq_phase == PH_STANDBY && $urandom_range(0, 7) == 0) begin
                send_item(mk_loop(1'($urandom_range(0, 1))));
                sent++;
                sender_pause();
            end
            send_item(mk_start(trans_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                               $urandom, 1'($urandom_range(0, 1)), pick_level(), $urandom,
                               pick_level(), 1'($urandom_range(0, 1))));
            sent++;
            sender_pause();
            cap = $urandom_range(4, 60);
            while (seq_phase != PH_STANDBY && cap > 0 && sent < n_items) begin
                send_item(mk_loop($urandom_range(0, 3) != 0));
                sent++;
                cap--;
                sender_pause();
            end
        end
    endtask

    // unstructured transactions: any kind, any field
    task automatic run_noise(input int n_items);
        item_t it;
        repeat (n_items) begin
            it = mk_loop(1'($urandom_range(0, 1)));
            it.kind = $urandom_range(0, 1) ? KIND_LOOP : KIND_START;
            send_item(it);
            sender_pause();
        end
    endtask

    task automatic run_phase(input logic anim, input logic [7:0] floor_lvl,
                             input logic [7:0] step, input int n_seq, input int n_noise);
        apply_settings(anim, floor_lvl, step);
        run_fade_sequences(n_seq);
        run_noise(n_noise);
    endtask

    // --------------------------------------------------------------------
    // tests
    // --------------------------------------------------------------------

    // hand-built walk through every transition, clamps and field extremes
    task automatic test_directed_cases();
        apply_settings(1'b0, 8'd16, 8'd64);
        // loop pass in standby does nothing
        send_item(mk_loop(1'b1));
        // immediate colour; step due on a start is ignored
        send_item(mk_start(TR_IMMEDIATE, 1'b1, 32'hFFFF_FFFF, 1'b1, 8'd255,
                           32'h0000_0000, 8'd0, 1'b1));
        send_item(mk_loop(1'b1));
        // full fade to colour from full brightness, including one idle pass
        send_item(mk_start(TR_FADE_COLOR, 1'b1, 32'h0000_0000, 1'b0, 8'd0,
                           32'hA5A5_A5A5, 8'd255, 1'b0));
        send_item(mk_loop(1'b1));
        send_item(mk_loop(1'b0));
        repeat (8) send_item(mk_loop(1'b1));
        // start during a fade abandons it
        send_item(mk_start(TR_FADE_COLOR, 1'b1, 32'h5A5A_5A5A, 1'b1, 8'd0,
                           32'hFFFF_FFFF, 8'd128, 1'b0));
        send_item(mk_loop(1'b1));
        send_item(mk_loop(1'b1));
        // fade out from zero brightness ramps up to the floor
        send_item(mk_start(TR_FADE_OUT, 1'b0, 32'h0, 1'b1, 8'd0, 32'h0000_0000, 8'd0, 1'b0));
        repeat (3) send_item(mk_loop(1'b1));
        // fade in up to a higher goal
        send_item(mk_start(TR_FADE_IN, 1'b0, 32'h0, 1'b1, 8'd255, 32'hFFFF_FFFF, 8'd200,
                           1'b1));
        repeat (3) send_item(mk_loop(1'b1));
        // immediate with a fresh black colour, step due on the loop pass
        send_item(mk_start(TR_IMMEDIATE, 1'b1, 32'h0000_0000, 1'b0, 8'd0, 32'h1234_5678,
                           8'd77, 1'b0));
        send_item(mk_loop(1'b1));
    endtask

    // register extremes, last one with no idling on either side
    task automatic test_register_extremes();
        run_phase(1'b1, 8'd255, 8'd255, 75, 15);
        run_phase(1'b0, 8'd0, 8'd1, 75, 15);
        run_phase(1'b1, 8'd0, 8'd255, 75, 15);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        run_phase(1'b0, 8'd255, 8'd1, 75, 15);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // a zero step holds the brightness but still writes it
    task automatic test_zero_ramp_step();
        run_phase(1'b1, 8'($urandom_range(0, 255)), 8'd0, 50, 10);
    endtask

    // sender stops mid-phase until every update is back, then carries on
    task automatic test_drain_midway();
        apply_settings(1'b0, 8'd40, 8'd7);
        run_fade_sequences(45);
        settle_pipeline();
        run_fade_sequences(40);
        run_noise(5);
    endtask

    task automatic test_random_settings();
        repeat (3) begin
            run_phase(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(1, 255)), 68, 12);
        end
    endtask

    // --------------------------------------------------------------------
    // receiver stall pattern
    // --------------------------------------------------------------------
    always @(posedge aclk) begin
        if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else if (m_ready && !rx_steady) begin
            m_ready <= 1'b0;
            rx_left <= $urandom_range(0, 7);
        end else begin
            m_ready <= 1'b1;
            rx_left <= $urandom_range(0, 20);
        end
    end

    // --------------------------------------------------------------------
    // result checker and watchdog
    // --------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t exp_upd;
        logic    bad;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) stuck_cycles <= 0;
            else stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STUCK_LIMIT);
                $display("led_fade_transition_sequencer_tb: done, errors");
                $finish;
            end
            if (m_valid && m_ready) begin
                if (strip_updates_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result bw=%0d bv=%0d cw=%0d cv=%h ph=%0d",
                                 $time, m_brightness_write, m_brightness_value,
                                 m_color_write, m_color_value, m_phase);
                end else begin
                    exp_upd = strip_updates_due.pop_front();
                    if (exp_upd.brightness_write) bri_writes++;
                    if (exp_upd.color_write) color_writes++;
                    bad = (m_brightness_write !== exp_upd.brightness_write)
                        | (m_brightness_value !== exp_upd.brightness_value)
                        | (m_color_write      !== exp_upd.color_write)
                        | (m_color_value      !== exp_upd.color_value)
                        | (m_phase            !== exp_upd.phase);
                    if (bad) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: mismatch exp bw=%0d bv=%0d cw=%0d cv=%h ph=%0d",
                                     $time, exp_upd.brightness_write,
                                     exp_upd.brightness_value, exp_upd.color_write,
                                     exp_upd.color_value, exp_upd.phase);
                            $display("%0t:          got bw=%0d bv=%0d cw=%0d cv=%h ph=%0d",
                                     $time, m_brightness_write, m_brightness_value,
                                     m_color_write, m_color_value, m_phase);
                        end
                    end
                end
            end
        end
    end

    // --------------------------------------------------------------------
    // main sequence
    // --------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_register_extremes();
        test_zero_ramp_step();
        test_drain_midway();
        test_random_settings();

        // wait for the tail, then stay quiet to catch anything stray
        s_valid <= 1'b0;
        while (strip_updates_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("covered %0d starts (fade-colour %0d, fade-out %0d, fade-in %0d, immediate %0d)"
                 , starts_by_type[0] + starts_by_type[1] + starts_by_type[2] + starts_by_type[3],
                 starts_by_type[0], starts_by_type[1], starts_by_type[2], starts_by_type[3]);
        $display({"%0d loop passes, %0d brightness writes, %0d colour writes, ",
                  "%0d settings, %0d mismatches"},
                 loop_count, bri_writes, color_writes, settings_count, mismatch_count);
        if (mismatch_count == 0 && strip_updates_due.size() == 0) begin
            $display("led_fade_transition_sequencer_tb: done, clean");
        end else begin
            $display("led_fade_transition_sequencer_tb: done, errors");
        end
        $finish;
    end

endmodule
